FILE: design/lambda_term_tokenizer_top_macros.svh
// Assertion macros for the lambda term tokenizer.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef LAMBDA_TERM_TOKENIZER_TOP_MACROS_SVH
`define LAMBDA_TERM_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LTT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication, disabled in reset
`define LTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

FILE: design/ltt_pkg.sv
// Shared types and constants for the lambda term tokenizer.
// No dependencies; imported by every tokenizer module.
package ltt_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 4;

   // Token kinds
   localparam logic [2:0] KIND_LAMBDA  = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_DOT     = 3'd2;
   localparam logic [2:0] KIND_LPAREN  = 3'd3;
   localparam logic [2:0] KIND_RPAREN  = 3'd4;
   localparam logic [2:0] KIND_INVALID = 3'd5;

   // Keyword match progress codes
   localparam logic [2:0] KW_NONE     = 3'd0;
   localparam logic [2:0] KW_FULL     = 3'd6;
   localparam logic [2:0] KW_MISMATCH = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last_of_run;
      logic        source_done;
   } token_type;

   // Results of one byte: one or two tokens
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two_tok;
   } entry_type;

   // Characters of the keyword "lambda"
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h6C; // l
         3'd1:    ch = 8'h61; // a
         3'd2:    ch = 8'h6D; // m
         3'd3:    ch = 8'h62; // b
         3'd4:    ch = 8'h64; // d
         3'd5:    ch = 8'h61; // a
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: design/ltt_front.sv
// Front end: accepts source bytes, tracks the pending word and builds tokens.
// Depends on ltt_pkg; pushes one entry per token-producing byte into ltt_queue.
module ltt_front import ltt_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_source,
   input  logic       q_full,
   output logic       push,
   output entry_type  push_entry
);

   localparam int DW = (POSITION_BITS + 1 > 17) ? POSITION_BITS + 1 : 17;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     pending_ff, pending_in;
   logic                     ident_ff, ident_in;
   logic [2:0]               kw_ff, kw_in;

   logic                     accept;
   logic [7:0]               c;
   logic                     is_alpha, is_digit, is_under, is_delim, is_sym;
   logic                     n_pending, n_ident;
   logic [POSITION_BITS-1:0] n_start;
   logic [2:0]               n_kw;
   logic [2:0]               cur_kind, new_kind, sym_kind;
   logic [DW-1:0]            pos_x, start_x, n_start_x, close_diff, final_diff;
   logic                     has_close, has_final;
   token_type                close_tok, sym_tok, final_tok;
   entry_type                entry;

   assign req_ready = ~q_full;
   assign accept    = req_valid & ~q_full;

   // Classify the byte
   always_comb begin
      c        = req_char_code;
      is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      is_digit = (c >= 8'h30 && c <= 8'h39);
      is_under = (c == CH_UNDER);
      is_sym   = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_DOT);
      is_delim = is_sym || (c == CH_SPACE) || (c == CH_TAB) ||
                 (c == CH_LF) || (c == CH_CR);
      if (c == CH_LPAREN) begin
         sym_kind = KIND_LPAREN;
      end else if (c == CH_RPAREN) begin
         sym_kind = KIND_RPAREN;
      end else begin
         sym_kind = KIND_DOT;
      end
   end

   // Advance the pending word
   always_comb begin
      if (is_delim) begin
         n_pending = 1'b0;
         n_start   = start_ff;
         n_ident   = 1'b1;
         n_kw      = KW_NONE;
      end else if (!pending_ff) begin
         n_pending = 1'b1;
         n_start   = pos_ff;
         n_ident   = is_alpha | is_under;
         n_kw      = (c == kw_char(KW_NONE)) ? 3'd1 : KW_MISMATCH;
      end else begin
         n_pending = 1'b1;
         n_start   = start_ff;
         n_ident   = ident_ff & (is_alpha | is_digit | is_under);
         n_kw      = (kw_ff < KW_FULL && c == kw_char(kw_ff)) ? kw_ff + 3'd1
                                                                : KW_MISMATCH;
      end
      cur_kind = (kw_ff == KW_FULL) ? KIND_LAMBDA : (ident_ff ? KIND_IDENT : KIND_INVALID);
      new_kind = (n_kw == KW_FULL) ? KIND_LAMBDA : (n_ident ? KIND_IDENT : KIND_INVALID);
   end

   // Build the tokens of this byte
   always_comb begin
      pos_x      = DW'(pos_ff);
      start_x    = DW'(start_ff);
      n_start_x  = DW'(n_start);
      close_diff = pos_x - start_x;
      final_diff = pos_x - n_start_x + DW'(1);

      close_tok.kind        = cur_kind;
      close_tok.start       = start_x[15:0];
      close_tok.length      = (close_diff > DW'(16'hFFFF)) ? 16'hFFFF : close_diff[15:0];
      close_tok.last_of_run = 1'b0;
      close_tok.source_done = 1'b0;

      sym_tok.kind        = sym_kind;
      sym_tok.start       = pos_x[15:0];
      sym_tok.length      = 16'd1;
      sym_tok.last_of_run = 1'b0;
      sym_tok.source_done = 1'b0;

      final_tok.kind        = new_kind;
      final_tok.start       = n_start_x[15:0];
      final_tok.length      = (final_diff > DW'(16'hFFFF)) ? 16'hFFFF : final_diff[15:0];
      final_tok.last_of_run = 1'b0;
      final_tok.source_done = 1'b0;

      has_close = is_delim & pending_ff;
      has_final = ~is_delim & req_end_of_source;

      entry.tok0    = has_close ? close_tok : (is_sym ? sym_tok : final_tok);
      entry.tok1    = sym_tok;
      entry.two_tok = has_close & is_sym;

      // Mark the last token of the run
      if (entry.two_tok) begin
         entry.tok1.last_of_run = 1'b1;
         entry.tok1.source_done = req_end_of_source;
      end else begin
         entry.tok0.last_of_run = 1'b1;
         entry.tok0.source_done = req_end_of_source;
      end
   end

   assign push       = accept & (has_close | is_sym | has_final);
   assign push_entry = entry;

   // Next word state; clear everything after the final byte
   always_comb begin
      pos_in     = pos_ff;
      start_in   = start_ff;
      pending_in = pending_ff;
      ident_in   = ident_ff;
      kw_in      = kw_ff;
      if (accept) begin
         if (req_end_of_source) begin
            pos_in     = '0;
            start_in   = '0;
            pending_in = 1'b0;
            ident_in   = 1'b1;
            kw_in      = KW_NONE;
         end else begin
            pos_in     = (pos_ff != '1) ? pos_ff + POSITION_BITS'(1) : pos_ff;
            start_in   = n_start;
            pending_in = n_pending;
            ident_in   = n_ident;
            kw_in      = n_kw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         start_ff   <= '0;
         pending_ff <= 1'b0;
         ident_ff   <= 1'b1;
         kw_ff      <= KW_NONE;
      end else begin
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         pending_ff <= pending_in;
         ident_ff   <= ident_in;
         kw_ff      <= kw_in;
      end
   end

endmodule

FILE: design/ltt_queue.sv
// Short entry queue between the tokenizer front and back ends.
// Depends on ltt_pkg and the assertion macros header.
`include "lambda_term_tokenizer_top_macros.svh"

module ltt_queue import ltt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head_entry,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign head_entry = entries_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? ((wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1)) : wr_ff;
      rd_in  = pop  ? ((rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_entry;
      end
   end

   `LTT_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH))
   `LTT_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `LTT_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !empty)
   `LTT_ASSERT_NEXT(a_cnt_grow, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + CNT_W'(1))

endmodule

FILE: design/ltt_back.sv
// Back end: plays out the one or two tokens of each queued entry.
// Depends on ltt_pkg; reads the head of ltt_queue.
module ltt_back import ltt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head_entry,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_lexeme_start,
   output logic [15:0] rsp_lexeme_length,
   output logic        rsp_last_of_run,
   output logic        rsp_source_done
);

   logic      sel_ff, sel_in;
   logic      beat;
   token_type tok;

   assign rsp_valid = ~empty;
   assign beat      = rsp_valid & rsp_ready;
   assign tok       = sel_ff ? head_entry.tok1 : head_entry.tok0;

   assign rsp_token_kind    = tok.kind;
   assign rsp_lexeme_start  = tok.start;
   assign rsp_lexeme_length = tok.length;
   assign rsp_last_of_run   = tok.last_of_run;
   assign rsp_source_done   = tok.source_done;

   // Drop the entry after its last token's beat
   always_comb begin
      pop    = 1'b0;
      sel_in = sel_ff;
      if (beat) begin
         if (!sel_ff && head_entry.two_tok) begin
            sel_in = 1'b1;
         end else begin
            sel_in = 1'b0;
            pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

FILE: design/lambda_term_tokenizer_top.sv
// Lambda term tokenizer: one source byte in per beat, zero to two tokens out.
// A byte's tokens are registered in the queue and offered from its head.
// Throughput: one byte per cycle while the queue has room; one token per cycle
// out while rsp_ready is high, with entries held in a four-entry queue.
// Reset (synchronous): clears position, word state and the queue.
module lambda_term_tokenizer_top import ltt_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_lexeme_start,
   output logic [15:0] rsp_lexeme_length,
   output logic        rsp_last_of_run,
   output logic        rsp_source_done
);

   logic      q_full, q_empty, q_push, q_pop;
   entry_type push_entry, head_entry;

   ltt_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_source (req_end_of_source),
      .q_full            (q_full),
      .push              (q_push),
      .push_entry        (push_entry)
   );

   ltt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   ltt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_entry        (head_entry),
      .empty             (q_empty),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_lexeme_start  (rsp_lexeme_start),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_source_done   (rsp_source_done)
   );

endmodule

FILE: tb/lambda_term_tokenizer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the lambda term tokenizer: watches both channels, predicts tokens.
// Depends on ltt_pkg for the token record and the kind and keyword codes.
module lambda_term_tokenizer_checker import ltt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_source,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_token_kind,
   input  logic [15:0] rsp_lexeme_start,
   input  logic [15:0] rsp_lexeme_length,
   input  logic        rsp_last_of_run,
   input  logic        rsp_source_done,
   output int          error_count,
   output int          tokens_waiting
);

   localparam int          POS_BITS     = POSITION_BITS_DEF;
   localparam logic [47:0] KEYWORD_TEXT = "lambda";
   localparam int          REPORT_MAX   = 10;

   // Shadow copy of the tokenizer's word tracking
   logic [POS_BITS-1:0] byte_pos;
   logic [POS_BITS-1:0] word_start;
   logic                word_open;
   logic                word_ident;
   logic [2:0]          kw_matched;

   token_type expected_tokens[$];

   initial begin
      error_count    = 0;
      tokens_waiting = 0;
   end

   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      return KEYWORD_TEXT[8 * (5 - idx) +: 8];
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return c == 8'h20 || c == 8'h28 || c == 8'h29 || c == 8'h2E ||
             c == 8'h0A || c == 8'h0D || c == 8'h09;
   endfunction

   function automatic logic [2:0] word_kind();
      if (kw_matched == KW_FULL) return KIND_LAMBDA;
      return word_ident ? KIND_IDENT : KIND_INVALID;
   endfunction

   task automatic clear_word_state();
      byte_pos   = '0;
      word_start = '0;
      word_open  = 1'b0;
      word_ident = 1'b1;
      kw_matched = KW_NONE;
   endtask

   task automatic log_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%s", msg);
   endtask

   // Queue one token; clip the length at 16 bits
   task automatic push_token(input logic [2:0] kind, input logic [POS_BITS-1:0] start,
                             input logic [POS_BITS:0] len);
      token_type tok;
      tok.kind        = kind;
      tok.start       = 16'(start);
      tok.length      = (len > 'hFFFF) ? 16'hFFFF : 16'(len);
      tok.last_of_run = 1'b0;
      tok.source_done = 1'b0;
      expected_tokens.insert(expected_tokens.size(), tok);
   endtask

   // Advance the shadow state by one source byte and queue its tokens
   task automatic tokenize_byte(input logic [7:0] ch, input logic fin);
      int                  first_new;
      int                  tail;
      logic [POS_BITS-1:0] pos;
      logic                body_ok;
      first_new = expected_tokens.size();
      pos       = byte_pos;
      if (is_separator(ch)) begin
         if (word_open) begin
            push_token(word_kind(), word_start,
                       (pos >= word_start) ? {1'b0, pos} - {1'b0, word_start} : '0);
         end
         if (ch == 8'h28) push_token(KIND_LPAREN, pos, 1);
         else if (ch == 8'h29) push_token(KIND_RPAREN, pos, 1);
         else if (ch == 8'h2E) push_token(KIND_DOT, pos, 1);
         word_open  = 1'b0;
         word_ident = 1'b1;
         kw_matched = KW_NONE;
      end else begin
         body_ok = is_letter(ch) || is_digit(ch) || ch == 8'h5F;
         if (!word_open) begin
            word_open  = 1'b1;
            word_start = pos;
            word_ident = is_letter(ch) || ch == 8'h5F;
            kw_matched = (ch == keyword_char(0)) ? 3'd1 : KW_MISMATCH;
         end else begin
            word_ident = word_ident && body_ok;
            if (kw_matched < KW_FULL && ch == keyword_char(kw_matched))
               kw_matched = kw_matched + 3'd1;
            else
               kw_matched = KW_MISMATCH;
         end
      end

      tail = expected_tokens.size() - 1;
      if (fin) begin
         // Flush a trailing word, then start the next source from zero
         if (word_open) begin
            push_token(word_kind(), word_start,
                       (pos >= word_start) ? {1'b0, pos} - {1'b0, word_start} + 1 : '0);
         end
         tail = expected_tokens.size() - 1;
         if (tail >= first_new) begin
            expected_tokens[tail].last_of_run = 1'b1;
            expected_tokens[tail].source_done = 1'b1;
         end
         clear_word_state();
      end else begin
         if (tail >= first_new) expected_tokens[tail].last_of_run = 1'b1;
         if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
      end
   endtask

   // Compare each output beat against the oldest expectation, then take input beats
   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         clear_word_state();
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_token_kind, rsp_lexeme_start, rsp_lexeme_length,
                    rsp_last_of_run, rsp_source_done};
            if (expected_tokens.size() == 0) begin
               log_failure($sformatf("unexpected token: kind %0d start %0d len %0d last %b done %b",
                                     got.kind, got.start, got.length,
                                     got.last_of_run, got.source_done));
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want) begin
                  log_failure($sformatf({"token mismatch: expected kind %0d start %0d len %0d",
                                         " last %b done %b, got kind %0d start %0d len %0d",
                                         " last %b done %b"},
                                        want.kind, want.start, want.length,
                                        want.last_of_run, want.source_done,
                                        got.kind, got.start, got.length,
                                        got.last_of_run, got.source_done));
               end
            end
         end
         if (req_valid && req_ready) tokenize_byte(req_char_code, req_end_of_source);
      end
      tokens_waiting <= expected_tokens.size();
   end

endmodule

FILE: tb/tb_lambda_term_tokenizer_top.sv
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, byte stimulus and the verdict.
// Depends on ltt_pkg, lambda_term_tokenizer_top and lambda_term_tokenizer_checker.
module tb_lambda_term_tokenizer_top;
   import ltt_pkg::*;

   localparam int          CYCLE_LIMIT  = 20000;
   localparam int          RANDOM_BYTES = 700;
   localparam int          CALM_BYTES   = 150;
   localparam logic [47:0] KEYWORD_TEXT = "lambda";

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code     = 8'h00;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_lexeme_start;
   logic [15:0] rsp_lexeme_length;
   logic        rsp_last_of_run;
   logic        rsp_source_done;

   logic idle_on     = 1'b1;
   int   error_count;
   int   tokens_waiting;
   int   cycle_count;
   int   bytes_sent  = 0;

   lambda_term_tokenizer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_lexeme_start  (rsp_lexeme_start),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_source_done   (rsp_source_done)
   );

   lambda_term_tokenizer_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_lexeme_start  (rsp_lexeme_start),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_source_done   (rsp_source_done),
      .error_count       (error_count),
      .tokens_waiting    (tokens_waiting)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stall the token side at random while idling is on
   always @(posedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= 25);
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] keyword_char(input int idx);
      return KEYWORD_TEXT[8 * (5 - idx) +: 8];
   endfunction

   // Letter or underscore, plus digits when not leading
   function automatic logic [7:0] ident_char(input logic leading);
      int pick;
      pick = $urandom_range(leading ? 52 : 62);
      if (pick < 26) return 8'(8'h61 + pick);
      if (pick < 52) return 8'(8'h41 + pick - 26);
      if (pick == 52) return CH_UNDER;
      return 8'(8'h30 + pick - 53);
   endfunction

   function automatic logic [7:0] delimiter_char();
      case ($urandom_range(6))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         3:       return CH_LF;
         4:       return CH_LPAREN;
         5:       return CH_RPAREN;
         default: return CH_DOT;
      endcase
   endfunction

   // Offer one byte, idling first at random, and hold it until taken
   task automatic send_byte(input logic [7:0] ch, input logic fin);
      while (idle_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_code     <= ch;
      req_end_of_source <= fin;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_text(input string text, input logic fin);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], fin && i == text.len() - 1);
   endtask

   // Hold off the byte side until every predicted token has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tokens_waiting != 0);
   endtask

   // One word of a chosen shape, usually followed by delimiters
   task automatic send_fragment();
      logic [7:0] word_bytes[$];
      int         shape;
      int         n;
      int         delims;
      logic       fin;
      fin    = ($urandom_range(11) == 0);
      delims = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 2);
      shape  = $urandom_range(5);
      n      = $urandom_range(1, 5);
      case (shape)
         0: for (int i = 0; i < 6; i++) word_bytes = {word_bytes, keyword_char(i)};
         1: for (int i = 0; i < n; i++) word_bytes = {word_bytes, keyword_char(i)};
         2: begin
            for (int i = 0; i < 6; i++) word_bytes = {word_bytes, keyword_char(i)};
            repeat (n) word_bytes = {word_bytes, ident_char(1'b0)};
         end
         3: begin
            word_bytes = {word_bytes, ident_char(1'b1)};
            repeat (n) word_bytes = {word_bytes, ident_char(1'b0)};
         end
         4: begin
            word_bytes = {word_bytes, 8'(8'h30 + $urandom_range(9))};
            repeat (n) word_bytes = {word_bytes, ident_char(1'b0)};
         end
         default: begin
            word_bytes = {word_bytes, ident_char(1'b1)};
            repeat (n) word_bytes = {word_bytes, ident_char(1'b0)};
            word_bytes[$urandom_range(n)] = 8'($urandom_range(255));
         end
      endcase
      foreach (word_bytes[i])
         send_byte(word_bytes[i], fin && delims == 0 && i == word_bytes.size() - 1);
      for (int d = 0; d < delims; d++) send_byte(delimiter_char(), fin && d == delims - 1);
   endtask

   // Mostly well-formed words, some raw bytes of any value
   task automatic send_random_until(input int goal);
      while (bytes_sent < goal) begin
         if ($urandom_range(4) == 0)
            send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
         else
            send_fragment();
      end
   endtask

   initial begin
      int random_base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every kind, a delimiter closing the source, high bytes,
      // a trailing keyword prefix and a final byte that yields nothing
      send_text("(lambda x.x)", 1'b1);
      send_text("_9", 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
      send_text("9)", 1'b0);
      send_text("la", 1'b1);
      send_byte(CH_SPACE, 1'b1);

      // Random: a calm stretch, then idling, with a full drain midway
      random_base = bytes_sent;
      idle_on <= 1'b0;
      send_random_until(random_base + CALM_BYTES);
      idle_on <= 1'b1;
      send_random_until(random_base + RANDOM_BYTES / 2);
      wait_drained();
      send_random_until(random_base + RANDOM_BYTES);

      // Let the last tokens out
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && tokens_waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
